// ===== hw/rtl/swsm_pkg.sv =====
// Shared constants for the sink/window slot manager: capacities, field widths,
// command codes and register indexes.
// Depends on nothing; modules refer to it by scoped names.
package swsm_pkg;

  localparam int unsigned MaxSink   = 16;
  localparam int unsigned MaxWindow = 1024;

  localparam int unsigned SinkW  = 5;   // sink length and sink fill
  localparam int unsigned WinW   = 11;  // window length and ring fill
  localparam int unsigned IdxW   = 10;  // ring index and physical index
  localparam int unsigned SlotW  = 11;  // assigned logical slot
  localparam int unsigned OccW   = 11;  // occupancy
  localparam int unsigned WordW  = 32;  // position and queried slot
  localparam int unsigned KindW  = 2;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned ApbW     = 32;

  localparam logic [KindW-1:0] KindAppend = 2'd0;
  localparam logic [KindW-1:0] KindGet    = 2'd1;
  localparam logic [KindW-1:0] KindEvict  = 2'd2;
  localparam logic [KindW-1:0] KindReset  = 2'd3;

  // Register selects, taken from address bit 2 (word registers at 0 and 4).
  localparam logic RegSinkLength   = 1'b0;
  localparam logic RegWindowLength = 1'b1;

  localparam logic [SinkW-1:0] SinkLengthReset   = 5'd4;
  localparam logic [WinW-1:0]  WindowLengthReset = 11'd1020;

endpackage

// ===== hw/rtl/sink_window_slot_manager_core.sv =====
// Slot manager for a key/value cache with a fixed sink region and a ring window.
// Uses swsm_pkg for widths, command codes and register selects.
//
// Usage: commands arrive on the s_axis channel (tuser carries the command kind,
// tdata the sequence position and the queried logical slot). Each command gives
// exactly one result transfer on the m_axis channel: tuser is the status flag,
// tdata holds region, physical index, assigned slot and occupancy.
// A command is taken into an input register, evaluated by one pass of compare,
// add and conditional-wrap logic on the small counters, and the result and the
// new counter values are registered together. A result is offered from the
// result register once its command has left the input register; one command is
// taken every cycle unless the output stalls, since the counters updated by one
// command are ready for the next.
// When the receiver stalls, the result register holds its transfer and the
// input register holds one more command; tready on the input drops only when
// both are occupied and m_axis_tready is low.
// Reset empties both pipeline registers, clears the sink fill, ring head and
// ring fill, and loads sink_length = 4 and window_length = 1020.
// The user writes the APB port (sink_length 0x0, window_length 0x4) only while
// no command is in flight, unenforced; a window_length write empties the window.
module sink_window_slot_manager_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] seq_position, [63:32] logical_slot
  input  logic [swsm_pkg::InDataW-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [swsm_pkg::KindW-1:0]   s_axis_tuser,
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] in_window, [10:1] phys_index, [21:11] slot_out, [32:22] occupancy,
  // [39:33] zero
  output logic [swsm_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] status
  output logic                         m_axis_tuser,
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swsm_pkg::AddrW-1:0]   paddr,
  input  logic [swsm_pkg::ApbW-1:0]    pwdata,
  output logic [swsm_pkg::ApbW-1:0]    prdata,
  output logic                         pready
);

  localparam int unsigned SinkW = swsm_pkg::SinkW;
  localparam int unsigned WinW  = swsm_pkg::WinW;
  localparam int unsigned IdxW  = swsm_pkg::IdxW;
  localparam int unsigned WordW = swsm_pkg::WordW;
  localparam int unsigned SumW  = WinW + 1;

  // Configuration registers
  logic [SinkW-1:0] sink_length_q;
  logic [WinW-1:0]  window_length_q;

  // Cache bookkeeping
  logic [SinkW-1:0] sink_fill_q, sink_fill_d;
  logic [IdxW-1:0]  ring_head_q, ring_head_d;
  logic [WinW-1:0]  ring_fill_q, ring_fill_d;

  // Input register
  logic                         in_valid_q;
  logic [swsm_pkg::KindW-1:0]   kind_q;
  logic [WordW-1:0]             pos_q;
  logic [WordW-1:0]             slot_q;

  // Result register
  logic             out_valid_q;
  logic             status_q, status_d;
  logic             in_window_q, in_window_d;
  logic [IdxW-1:0]  phys_q, phys_d;
  logic [swsm_pkg::SlotW-1:0] slot_out_q, slot_out_d;
  logic [swsm_pkg::OccW-1:0]  occ_q, occ_d;

  logic advance, step, cfg_wr;
  logic [SinkW-1:0] s_eff;
  logic [WinW-1:0]  w_eff;
  logic [SumW-1:0]  tail_sum, head_inc_sum, get_sum;
  logic [IdxW-1:0]  tail_idx, head_inc_idx, get_idx;
  logic [WordW-1:0] slot_rel;
  logic             get_in_sink, get_in_ring, pos_in_sink;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  assign prdata = (paddr[2] == swsm_pkg::RegWindowLength)
                ? {{(swsm_pkg::ApbW-WinW){1'b0}}, window_length_q}
                : {{(swsm_pkg::ApbW-SinkW){1'b0}}, sink_length_q};

  assign advance       = ~out_valid_q | m_axis_tready;
  assign step          = in_valid_q & advance;
  assign s_axis_tready = ~in_valid_q | advance;

  // Effective sizes: the sink is capped, the window is clamped to 1..MaxWindow.
  always_comb begin
    s_eff = (sink_length_q > SinkW'(swsm_pkg::MaxSink)) ? SinkW'(swsm_pkg::MaxSink)
                                                        : sink_length_q;
    if (window_length_q == '0) begin
      w_eff = WinW'(1);
    end else if (window_length_q > WinW'(swsm_pkg::MaxWindow)) begin
      w_eff = WinW'(swsm_pkg::MaxWindow);
    end else begin
      w_eff = window_length_q;
    end
  end

  // Ring arithmetic. The head stays below the window and the fill at or below
  // it, so every sum used is below twice the window; one subtraction wraps it.
  always_comb begin
    tail_sum     = {2'b00, ring_head_q} + {1'b0, ring_fill_q};
    tail_sum     = (tail_sum >= {1'b0, w_eff}) ? tail_sum - {1'b0, w_eff} : tail_sum;
    tail_idx     = tail_sum[IdxW-1:0];

    head_inc_sum = {2'b00, ring_head_q} + SumW'(1);
    head_inc_sum = (head_inc_sum >= {1'b0, w_eff}) ? head_inc_sum - {1'b0, w_eff}
                                                   : head_inc_sum;
    head_inc_idx = head_inc_sum[IdxW-1:0];

    slot_rel     = slot_q - {{(WordW-SinkW){1'b0}}, s_eff};
    get_sum      = {2'b00, ring_head_q} + {1'b0, slot_rel[WinW-1:0]};
    get_sum      = (get_sum >= {1'b0, w_eff}) ? get_sum - {1'b0, w_eff} : get_sum;
    get_idx      = get_sum[IdxW-1:0];

    get_in_sink  = slot_q < {{(WordW-SinkW){1'b0}}, sink_fill_q};
    get_in_ring  = (slot_q >= {{(WordW-SinkW){1'b0}}, s_eff})
                 && (slot_rel < {{(WordW-WinW){1'b0}}, ring_fill_q});
    pos_in_sink  = pos_q < {{(WordW-SinkW){1'b0}}, s_eff};
  end

  // One command against the current counters.
  always_comb begin
    sink_fill_d = sink_fill_q;
    ring_head_d = ring_head_q;
    ring_fill_d = ring_fill_q;
    status_d    = 1'b0;
    in_window_d = 1'b0;
    phys_d      = '0;
    slot_out_d  = '0;
    case (kind_q)
      swsm_pkg::KindAppend: begin
        if (pos_in_sink) begin
          phys_d     = IdxW'(pos_q[SinkW-1:0]);
          slot_out_d = swsm_pkg::SlotW'(pos_q[SinkW-1:0]);
          if (pos_q[SinkW-1:0] >= sink_fill_q) begin
            sink_fill_d = pos_q[SinkW-1:0] + SinkW'(1);
          end
        end else begin
          in_window_d = 1'b1;
          if (ring_fill_q < w_eff) begin
            phys_d      = tail_idx;
            ring_fill_d = ring_fill_q + WinW'(1);
          end else begin
            // Full window: the oldest entry is overwritten.
            phys_d      = ring_head_q;
            ring_head_d = head_inc_idx;
          end
          slot_out_d = swsm_pkg::SlotW'(s_eff) + swsm_pkg::SlotW'(phys_d);
        end
      end
      swsm_pkg::KindGet: begin
        if (get_in_sink) begin
          phys_d = IdxW'(slot_q[SinkW-1:0]);
        end else if (get_in_ring) begin
          in_window_d = 1'b1;
          phys_d      = get_idx;
        end else begin
          status_d = 1'b1;
        end
      end
      swsm_pkg::KindEvict: begin
        if (ring_fill_q != '0) begin
          ring_head_d = head_inc_idx;
          ring_fill_d = ring_fill_q - WinW'(1);
        end
      end
      swsm_pkg::KindReset: begin
        ring_head_d = '0;
        ring_fill_d = '0;
      end
      default: begin
        status_d = 1'b0;
      end
    endcase
    occ_d = swsm_pkg::OccW'(sink_fill_d) + ring_fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_length_q   <= swsm_pkg::SinkLengthReset;
      window_length_q <= swsm_pkg::WindowLengthReset;
      sink_fill_q     <= '0;
      ring_head_q     <= '0;
      ring_fill_q     <= '0;
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        sink_fill_q <= sink_fill_d;
        ring_head_q <= ring_head_d;
        ring_fill_q <= ring_fill_d;
      end
      if (cfg_wr) begin
        if (paddr[2] == swsm_pkg::RegWindowLength) begin
          window_length_q <= pwdata[WinW-1:0];
          ring_head_q     <= '0;
          ring_fill_q     <= '0;
        end else begin
          sink_length_q <= pwdata[SinkW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      pos_q  <= s_axis_tdata[WordW-1:0];
      slot_q <= s_axis_tdata[2*WordW-1:WordW];
    end
    if (step) begin
      status_q    <= status_d;
      in_window_q <= in_window_d;
      phys_q      <= phys_d;
      slot_out_q  <= slot_out_d;
      occ_q       <= occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'b0, occ_q, slot_out_q, phys_q, in_window_q};

`ifndef SYNTHESIS
  a_fill_le_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_fill_q <= w_eff)
    else $error("ring fill exceeds the effective window");

  a_head_lt_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_head_q < IdxW'(w_eff - WinW'(1)) + IdxW'(1) || w_eff == WinW'(swsm_pkg::MaxWindow))
    else $error("ring head outside the effective window");

  a_sink_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sink_fill_q <= SinkW'(swsm_pkg::MaxSink))
    else $error("sink fill above sink capacity");

  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !cfg_wr) |=> occ_q == swsm_pkg::OccW'(sink_fill_q) + ring_fill_q)
    else $error("reported occupancy differs from the counters");

  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q) |-> (!in_window_q && phys_q == '0 && slot_out_q == '0))
    else $error("invalid get carries non-zero fields");
`endif

endmodule
